FILE: rtl/fdid_pkg.sv
`default_nettype none
package fdid_pkg;

    localparam int unsigned FRAME_PIXELS = 64000;
    localparam int unsigned STORE_DEPTH  = 65536;
    localparam int unsigned ADDR_W       = 16;
    localparam int unsigned POS_W        = 17;

    typedef enum logic [2:0] {
        OP_LITERAL   = 3'd0,
        OP_LONG_SKIP = 3'd1,
        OP_SKIP      = 3'd2,
        OP_WORD_FILL = 3'd3,
        OP_BYTE_FILL = 3'd4,
        OP_FILL      = 3'd5,
        OP_REL_REF   = 3'd6,
        OP_ABS_REF   = 3'd7
    } opcode_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  code_byte;
        logic [15:0] read_address;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic        frame_done;
        logic [15:0] write_position;
    } out_item_t;

    function automatic logic [1:0] cmd_last(input opcode_t op);
        logic [1:0] r;
        begin
            case (op)
                OP_LITERAL:   r = 2'd0;
                OP_LONG_SKIP: r = 2'd1;
                OP_SKIP:      r = 2'd0;
                OP_WORD_FILL: r = 2'd3;
                OP_BYTE_FILL: r = 2'd2;
                OP_FILL:      r = 2'd1;
                OP_REL_REF:   r = 2'd2;
                OP_ABS_REF:   r = 2'd2;
                default:      r = 2'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/frame_delta_image_decoder.sv
// Frame delta image decoder. Takes one input beat at a time: a compressed byte
// (kind 0) or a pixel read (kind 1), and returns one result beat per input
// beat. The frame lives in a 64 Ki x 8 synchronous RAM with one write port and
// one read port. After reset a clearing pass writes zero to every entry, one
// per cycle, during which no input beat is taken. A plain command byte, a skip
// or a literal data byte passes through the output state alone; a pixel read
// first reads the RAM, then outputs; a fill writes its pixels, and a
// back-reference copy reads each pixel, then writes it, before the output state.
// A stalled result beat holds off the next input beat until it is taken.
`default_nettype none
module frame_delta_image_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire fdid_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output fdid_pkg::out_item_t     out_data
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_FILL, S_CRD, S_CWR, S_RRD, S_OUT
    } state_t;

    logic [7:0] mem [fdid_pkg::STORE_DEPTH];

    state_t                      state_reg;
    logic [fdid_pkg::POS_W-1:0]  pos_reg;
    fdid_pkg::opcode_t           op_reg;
    logic [23:0]                 cmd_reg;
    logic [1:0]                  gath_reg;
    logic [5:0]                  lit_reg;
    logic [16:0]                 cnt_reg;
    logic [7:0]                  va_reg, vb_reg;
    logic                        alt_reg;
    logic [15:0]                 src_reg;
    logic [15:0]                 clr_reg;
    logic                        done_reg;
    logic                        rdpix_reg;
    logic [7:0]                  pix_reg;

    logic                        we;
    logic [15:0]                 waddr, raddr;
    logic [7:0]                  wdata, rdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    logic       wr_ok;
    logic [7:0] b;
    logic [1:0] g;
    fdid_pkg::opcode_t op_now;
    logic [fdid_pkg::POS_W-1:0] pos_base;
    logic [12:0] n13;
    logic [23:0] prev;

    assign in_stall = (state_reg != S_IDLE);
    assign wr_ok    = (pos_reg[16] == 1'b0);
    assign b        = in_data.code_byte;
    assign prev     = cmd_reg;
    assign g        = gath_reg;

    always_comb
    begin
        pos_base = pos_reg;
        op_now   = op_reg;
        if (gath_reg == 2'd0)
        begin
            if (pos_reg >= 17'(fdid_pkg::FRAME_PIXELS))
            begin
                pos_base = '0;
            end
            op_now = fdid_pkg::opcode_t'(b[7:5]);
        end
        n13 = {prev[12:8], prev[7:0]};
        we    = 1'b0;
        waddr = pos_reg[15:0];
        wdata = 8'd0;
        raddr = in_data.read_address;
        case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
            end
            S_IDLE:
            begin
                if (in_valid && !in_data.kind && lit_reg != 6'd0 && wr_ok)
                begin
                    we    = 1'b1;
                    wdata = b;
                end
            end
            S_FILL:
            begin
                we    = wr_ok;
                wdata = alt_reg ? vb_reg : va_reg;
            end
            S_CRD:
            begin
                raddr = src_reg;
            end
            S_CWR:
            begin
                we    = wr_ok;
                wdata = rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pos_reg   <= '0;
            op_reg    <= fdid_pkg::OP_LITERAL;
            cmd_reg   <= '0;
            gath_reg  <= '0;
            lit_reg   <= '0;
            clr_reg   <= '0;
            out_valid <= 1'b0;
            cnt_reg   <= '0;
            alt_reg   <= 1'b0;
            done_reg  <= 1'b0;
            rdpix_reg <= 1'b0;
            pix_reg   <= '0;
            va_reg    <= '0;
            vb_reg    <= '0;
            src_reg   <= '0;
            out_data  <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 16'd1;
                    if (clr_reg == 16'hFFFF)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    done_reg  <= 1'b0;
                    rdpix_reg <= 1'b0;
                    if (in_valid)
                    begin
                        state_reg <= S_OUT;
                        if (in_data.kind)
                        begin
                            rdpix_reg <= 1'b1;
                            state_reg <= S_RRD;
                        end
                        else if (lit_reg != 6'd0)
                        begin
                            pos_reg <= pos_reg + 17'd1;
                            lit_reg <= lit_reg - 6'd1;
                            if (lit_reg == 6'd1 &&
                                (pos_reg + 17'd1) >= 17'(fdid_pkg::FRAME_PIXELS))
                            begin
                                done_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            pos_reg <= pos_base;
                            op_reg  <= op_now;
                            if (g < fdid_pkg::cmd_last(op_now))
                            begin
                                cmd_reg  <= {prev[15:0], b};
                                gath_reg <= g + 2'd1;
                            end
                            else
                            begin
                                cmd_reg  <= '0;
                                gath_reg <= '0;
                                case (op_now)
                                    fdid_pkg::OP_LITERAL:
                                    begin
                                        lit_reg <= {1'b0, b[4:0]} + 6'd1;
                                    end
                                    fdid_pkg::OP_LONG_SKIP:
                                    begin
                                        pos_reg <= pos_base
                                            + 17'({prev[4:0], b}) + 17'd1;
                                        done_reg <= (pos_base + 17'({prev[4:0], b})
                                            + 17'd1) >= 17'(fdid_pkg::FRAME_PIXELS);
                                    end
                                    fdid_pkg::OP_SKIP:
                                    begin
                                        pos_reg <= pos_base + 17'(b[4:0]) + 17'd1;
                                        done_reg <= (pos_base + 17'(b[4:0]) + 17'd1)
                                            >= 17'(fdid_pkg::FRAME_PIXELS);
                                    end
                                    fdid_pkg::OP_WORD_FILL:
                                    begin
                                        va_reg    <= prev[7:0];
                                        vb_reg    <= b;
                                        alt_reg   <= 1'b0;
                                        cnt_reg   <= 17'({prev[20:16], prev[15:8], 1'b0});
                                        state_reg <= ({prev[20:16], prev[15:8]} == 13'd0)
                                                     ? S_OUT : S_FILL;
                                    end
                                    fdid_pkg::OP_BYTE_FILL:
                                    begin
                                        va_reg    <= b;
                                        vb_reg    <= b;
                                        alt_reg   <= 1'b0;
                                        cnt_reg   <= 17'({prev[12:8], prev[7:0]}) + 17'd1;
                                        state_reg <= S_FILL;
                                    end
                                    fdid_pkg::OP_FILL:
                                    begin
                                        va_reg    <= b;
                                        vb_reg    <= b;
                                        alt_reg   <= 1'b0;
                                        cnt_reg   <= 17'(prev[4:0]) + 17'd1;
                                        state_reg <= S_FILL;
                                    end
                                    fdid_pkg::OP_REL_REF:
                                    begin
                                        src_reg   <= pos_base[15:0] - 16'(n13) - 16'd1;
                                        cnt_reg   <= 17'(b) + 17'd1;
                                        state_reg <= S_CRD;
                                    end
                                    default:
                                    begin
                                        src_reg   <= {b, prev[7:0]};
                                        cnt_reg   <= 17'(prev[12:8]) + 17'd1;
                                        state_reg <= S_CRD;
                                    end
                                endcase
                                if (op_now == fdid_pkg::OP_WORD_FILL
                                    && {prev[20:16], prev[15:8]} == 13'd0)
                                begin
                                    done_reg <= pos_base >= 17'(fdid_pkg::FRAME_PIXELS);
                                end
                            end
                        end
                    end
                end
                S_FILL:
                begin
                    pos_reg <= pos_reg + 17'd1;
                    alt_reg <= ~alt_reg;
                    cnt_reg <= cnt_reg - 17'd1;
                    if (cnt_reg == 17'd1)
                    begin
                        state_reg <= S_OUT;
                        done_reg  <= (pos_reg + 17'd1) >= 17'(fdid_pkg::FRAME_PIXELS);
                    end
                end
                S_CRD:
                begin
                    state_reg <= S_CWR;
                end
                S_CWR:
                begin
                    pos_reg <= pos_reg + 17'd1;
                    src_reg <= src_reg + 16'd1;
                    cnt_reg <= cnt_reg - 17'd1;
                    if (cnt_reg == 17'd1)
                    begin
                        state_reg <= S_OUT;
                        done_reg  <= (pos_reg + 17'd1) >= 17'(fdid_pkg::FRAME_PIXELS);
                    end
                    else
                    begin
                        state_reg <= S_CRD;
                    end
                end
                S_RRD:
                begin
                    pix_reg   <= rdata;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        out_valid                <= 1'b1;
                        out_data.pixel_value     <= rdpix_reg ? pix_reg : 8'd0;
                        out_data.frame_done      <= done_reg;
                        out_data.write_position  <= pos_reg[16] ? 16'hFFFF
                                                               : pos_reg[15:0];
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (out_valid && !out_stall && !(state_reg == S_OUT))
            begin
                out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fdid_checker.sv
`default_nettype none
module fdid_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire fdid_pkg::in_item_t  in_data,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire fdid_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_take_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken in consecutive cycles");

    a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_done |->
        out_data.write_position >= 16'(fdid_pkg::FRAME_PIXELS) ||
        out_data.write_position == 16'hFFFF)
        else $error("frame done before frame end");

endmodule

bind frame_delta_image_decoder fdid_checker u_fdid_checker (.*);
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    class frame_scoreboard;
        byte unsigned          pixels [0:65535];
        bit [16:0]             position;
        fdid_pkg::opcode_t     held_op;
        bit [23:0]             held_bytes;
        bit [1:0]              held_count;
        bit [5:0]              literal_left;
        fdid_pkg::out_item_t   awaited [$];
        int                    mismatches;

        function void clear_all();
            foreach (pixels[i]) pixels[i] = 8'h00;
            position = '0;
            held_op = fdid_pkg::OP_LITERAL;
            held_bytes = '0;
            held_count = '0;
            literal_left = '0;
            awaited.delete();
            mismatches = 0;
        endfunction

        function void put(byte unsigned v);
            if (position < 17'(fdid_pkg::STORE_DEPTH)) pixels[position[15:0]] = v;
            position = position + 17'd1;
        endfunction

        function bit [1:0] last_index(fdid_pkg::opcode_t op);
            case (op)
                fdid_pkg::OP_LONG_SKIP, fdid_pkg::OP_FILL:
                    return 2'd1;
                fdid_pkg::OP_WORD_FILL:
                    return 2'd3;
                fdid_pkg::OP_BYTE_FILL, fdid_pkg::OP_REL_REF, fdid_pkg::OP_ABS_REF:
                    return 2'd2;
                default:
                    return 2'd0;
            endcase
        endfunction

        function void execute(fdid_pkg::opcode_t op, byte unsigned b0, byte unsigned b1,
                              byte unsigned b2, byte unsigned b3);
            int n;
            bit [15:0] a;
            n = 0;
            case (op)
                fdid_pkg::OP_LITERAL:
                    literal_left = 6'(b0[4:0]) + 6'd1;
                fdid_pkg::OP_LONG_SKIP:
                    position = position + 17'({b0[4:0], b1}) + 17'd1;
                fdid_pkg::OP_SKIP:
                    position = position + 17'(b0[4:0]) + 17'd1;
                fdid_pkg::OP_WORD_FILL:
                begin
                    n = int'({b0[4:0], b1});
                    for (int i = 0; i < n; i++)
                    begin
                        put(b2);
                        put(b3);
                    end
                end
                fdid_pkg::OP_BYTE_FILL:
                begin
                    n = int'({b0[4:0], b1}) + 1;
                    for (int i = 0; i < n; i++) put(b2);
                end
                fdid_pkg::OP_FILL:
                begin
                    n = int'(b0[4:0]) + 1;
                    for (int i = 0; i < n; i++) put(b1);
                end
                fdid_pkg::OP_REL_REF:
                begin
                    a = position[15:0] - (16'({b0[4:0], b1}) + 16'd1);
                    n = int'(b2) + 1;
                    for (int i = 0; i < n; i++)
                    begin
                        put(pixels[a]);
                        a = a + 16'd1;
                    end
                end
                default:
                begin
                    n = int'(b0[4:0]) + 1;
                    a = {b2, b1};
                    for (int i = 0; i < n; i++)
                    begin
                        put(pixels[a]);
                        a = a + 16'd1;
                    end
                end
            endcase
        endfunction

        function void note_input(fdid_pkg::in_item_t it);
            fdid_pkg::out_item_t r;
            bit ended;
            byte unsigned b [4];
            ended = 1'b0;
            r = '0;
            if (it.kind)
                r.pixel_value = pixels[it.read_address];
            else if (literal_left != 0)
            begin
                put(it.code_byte);
                literal_left = literal_left - 6'd1;
                ended = (literal_left == 0);
            end
            else
            begin
                if (held_count == 0)
                begin
                    if (position >= 17'(fdid_pkg::FRAME_PIXELS)) position = '0;
                    held_op = fdid_pkg::opcode_t'(it.code_byte[7:5]);
                end
                if (held_count >= last_index(held_op))
                begin
                    for (int i = 0; i < 4; i++) b[i] = 0;
                    for (int i = 0; i < held_count; i++)
                        b[i] = held_bytes[8 * (held_count - 1 - i) +: 8];
                    b[held_count] = it.code_byte;
                    held_count = '0;
                    held_bytes = '0;
                    execute(held_op, b[0], b[1], b[2], b[3]);
                    ended = (literal_left == 0);
                end
                else
                begin
                    held_bytes = {held_bytes[15:0], it.code_byte};
                    held_count = held_count + 2'd1;
                end
            end
            r.frame_done = ended && position >= 17'(fdid_pkg::FRAME_PIXELS);
            r.write_position = (position > 17'hFFFF) ? 16'hFFFF : position[15:0];
            awaited.push_back(r);
        endfunction

        function void check_result(fdid_pkg::out_item_t got);
            fdid_pkg::out_item_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            want = awaited.pop_front();
            if (got.pixel_value !== want.pixel_value || got.frame_done !== want.frame_done
                || got.write_position !== want.write_position)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected pix %h done %b pos %h, ",
                              "got pix %h done %b pos %h"},
                             want.pixel_value, want.frame_done, want.write_position,
                             got.pixel_value, got.frame_done, got.write_position);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    fdid_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    fdid_pkg::out_item_t out_data;
    bit                  hold_off;

    frame_scoreboard     board;
    fdid_pkg::in_item_t  stream [$];

    frame_delta_image_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic push_byte(byte unsigned v);
        fdid_pkg::in_item_t it;
        it.kind = 1'b0;
        it.code_byte = v;
        it.read_address = 16'($urandom);
        stream.push_back(it);
    endtask

    task automatic push_read(bit [15:0] a);
        fdid_pkg::in_item_t it;
        it.kind = 1'b1;
        it.code_byte = 8'($urandom);
        it.read_address = a;
        stream.push_back(it);
    endtask

    task automatic push_command(fdid_pkg::opcode_t op, bit [4:0] low, byte unsigned b1,
                                byte unsigned b2, byte unsigned b3);
        push_byte({op, low});
        case (op)
            fdid_pkg::OP_LONG_SKIP, fdid_pkg::OP_FILL:
                push_byte(b1);
            fdid_pkg::OP_BYTE_FILL, fdid_pkg::OP_REL_REF, fdid_pkg::OP_ABS_REF:
            begin
                push_byte(b1);
                push_byte(b2);
            end
            fdid_pkg::OP_WORD_FILL:
            begin
                push_byte(b1);
                push_byte(b2);
                push_byte(b3);
            end
            fdid_pkg::OP_LITERAL:
                for (int i = 0; i <= int'(low); i++) push_byte(8'($urandom));
            default:
            begin
            end
        endcase
    endtask

    task automatic build_directed();
        push_read(16'h0000);
        push_command(fdid_pkg::OP_LITERAL, 5'd2, 0, 0, 0);
        push_command(fdid_pkg::OP_FILL, 5'd31, 8'hFF, 0, 0);
        push_command(fdid_pkg::OP_WORD_FILL, 5'd0, 8'h00, 8'hA5, 8'h5A);
        push_command(fdid_pkg::OP_WORD_FILL, 5'd0, 8'h03, 8'h11, 8'h22);
        push_command(fdid_pkg::OP_SKIP, 5'd31, 0, 0, 0);
        push_command(fdid_pkg::OP_LONG_SKIP, 5'd0, 8'h10, 0, 0);
        push_command(fdid_pkg::OP_BYTE_FILL, 5'd0, 8'h04, 8'h77, 0);
        push_command(fdid_pkg::OP_REL_REF, 5'd0, 8'h02, 8'h09, 0);
        push_command(fdid_pkg::OP_ABS_REF, 5'd3, 8'h00, 8'h00, 0);
        push_command(fdid_pkg::OP_ABS_REF, 5'd4, 8'hFE, 8'hFF, 0);
        push_read(16'hFFFF);
        push_read(16'h0003);
        repeat (7) push_command(fdid_pkg::OP_LONG_SKIP, 5'd31, 8'hFF, 0, 0);
        push_command(fdid_pkg::OP_LITERAL, 5'd31, 0, 0, 0);
        push_read(16'hFA00);
        push_command(fdid_pkg::OP_FILL, 5'd1, 8'h3C, 0, 0);
    endtask

    task automatic build_random(int count);
        int k;
        bit [4:0] low;
        byte unsigned b1;
        fdid_pkg::opcode_t op;
        while (stream.size() < count)
        begin
            k = $urandom_range(0, 99);
            low = 5'($urandom);
            b1 = 8'($urandom);
            op = fdid_pkg::opcode_t'(3'($urandom_range(0, 7)));
            if (k < 10)
                push_read(16'($urandom));
            else if (k < 14)
                push_byte(8'($urandom));
            else if (k < 22)
            begin
                push_command(fdid_pkg::OP_LONG_SKIP, 5'd31, 8'hFF, 0, 0);
                push_command(fdid_pkg::OP_LONG_SKIP, low, b1, 0, 0);
            end
            else
            begin
                if (op == fdid_pkg::OP_BYTE_FILL || op == fdid_pkg::OP_WORD_FILL
                    || op == fdid_pkg::OP_REL_REF || op == fdid_pkg::OP_LONG_SKIP)
                begin
                    if ($urandom_range(0, 19) != 0)
                    begin
                        low = 5'd0;
                        b1 = 8'($urandom_range(0, 40));
                    end
                end
                push_command(op, low, b1, 8'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic send_all();
        fdid_pkg::in_item_t it;
        int gap;
        while (stream.size() != 0)
        begin
            it = stream.pop_front();
            gap = $urandom_range(0, 3);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data <= it;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            board.note_input(it);
            @(negedge clk);
        end
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall) board.check_result(out_data);

    initial
    begin
        int gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else
            begin
                gap = $urandom_range(0, 3);
                out_stall <= (gap != 0) && ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial
    begin
        wait (board != null);
        @(posedge rst_n);
        repeat (70000) @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #400ms;
        $display("frame_delta_image_decoder: mismatch");
        $finish;
    end

    initial
    begin
        int tail;
        board = new();
        board.clear_all();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        build_directed();
        send_all();
        build_random(2000);
        send_all();
        tail = 0;
        while (board.awaited.size() != 0 && tail < 200000)
        begin
            @(posedge clk);
            tail++;
        end
        repeat (50) @(posedge clk);
        if (board.mismatches == 0 && board.awaited.size() == 0)
            $display("frame_delta_image_decoder: match");
        else
            $display("frame_delta_image_decoder: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

FILE: frame_delta_image_decoder.f
rtl/fdid_pkg.sv
rtl/frame_delta_image_decoder.sv
rtl/fdid_checker.sv
dv/testbench.sv
